// ----- rtl/clq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clq_pkg
// Shared constants and types for the C-LOOK request queue.
// ----------------------------------------------------------------------------
package clq_pkg;

  localparam int DEPTH      = 32;
  localparam int TRACK_BITS = 16;
  localparam int TAG_BITS   = 8;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Kinds of input word, carried on tuser.
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [TRACK_BITS-1:0] track;
  } entry_t;

  // Operation applied to all cells of a whole store together.
  typedef struct packed {
    logic ins;
    logic pop;
  } op_t;

endpackage
`default_nettype wire

// ----- rtl/clq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clq_cell
// One slot of a sorted store: holds, inserts or shifts one entry.
// ----------------------------------------------------------------------------
module clq_cell (
  input  wire logic              clk,
  input  wire clq_pkg::op_t      op,
  input  wire clq_pkg::entry_t   new_entry,
  input  wire clq_pkg::entry_t   left_entry,
  input  wire clq_pkg::entry_t   right_entry,
  input  wire logic              left_after,
  input  wire logic              occupied,
  output clq_pkg::entry_t        entry,
  output logic                   after
);

  // The new entry belongs at or before this slot when the slot is free or
  // holds a strictly larger track, so equal tracks keep their arrival order.
  assign after = !occupied || (entry.track > new_entry.track);

  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (left_after) begin
        entry <= left_entry;
      end else if (after) begin
        entry <= new_entry;
      end
    end else if (op.pop) begin
      entry <= right_entry;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/clq_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clq_store
// Ascending track-sorted store built as a row of cells with a fill count.
// ----------------------------------------------------------------------------
module clq_store (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire clq_pkg::op_t           op,
  input  wire clq_pkg::entry_t        new_entry,
  output clq_pkg::entry_t             head,
  output logic [clq_pkg::CNT_W-1:0]   count,
  output logic                        full,
  output logic                        empty
);

  clq_pkg::entry_t entries [clq_pkg::DEPTH];
  logic            after_w [clq_pkg::DEPTH];

  assign head  = entries[0];
  assign full  = (count == clq_pkg::CNT_W'(clq_pkg::DEPTH));
  assign empty = (count == '0);

  for (genvar i = 0; i < clq_pkg::DEPTH; i++) begin : g_cell
    clq_pkg::entry_t left_e;
    clq_pkg::entry_t right_e;
    logic            left_a;

    if (i == 0) begin : g_first
      assign left_e = new_entry;
      assign left_a = 1'b0;
    end else begin : g_rest
      assign left_e = entries[i-1];
      assign left_a = after_w[i-1];
    end

    if (i == clq_pkg::DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    clq_cell u_cell (
      .clk         (clk),
      .op          (op),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .left_after  (left_a),
      .occupied    (clq_pkg::CNT_W'(i) < count),
      .entry       (entries[i]),
      .after       (after_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (op.ins) begin
      count <= count + 1'b1;
    end else if (op.pop) begin
      count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/c_look_request_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c_look_request_queue
// C-LOOK disk request queue with two sorted stores of systolic cells.
// ----------------------------------------------------------------------------
// Words arrive on the s_ channel: tuser selects add (0) or get (1), tdata
// carries tag, request track and head track. Every input word gives exactly
// one result word on the m_ channel, in the cycle after it is accepted.
// An add places the request in the upper store when its track is at or above
// the head, otherwise in the lower store; each store is a row of cells that
// all compare against the new track and shift in the same cycle. A get pops
// the smallest upper entry, or the smallest lower entry if the upper store
// is empty. A get on an empty queue and an add to a full store are flagged
// in the result status.
// Throughput is one word per cycle unless the receiver stalls; the single
// compare-and-shift step of the cell row sets that figure. The result sits in
// an output register; while the receiver stalls with a result pending, s_tready is low.
// Reset empties both stores at once (the fill counts clear) and drops any
// pending result.
// ----------------------------------------------------------------------------
module c_look_request_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // req_tag[7:0], req_track[23:8], head_track[39:24]
  input  wire logic [0:0]  s_tuser,  // func[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // out_tag[7:0], out_track[23:8], queue_empty[24], zeros
  output logic [2:0]       m_tuser   // out_valid[0], status[2:1]
);

  localparam int TB = clq_pkg::TAG_BITS;
  localparam int KB = clq_pkg::TRACK_BITS;

  logic                  accept;
  logic                  is_get;
  logic [TB-1:0]         req_tag;
  logic [KB-1:0]         req_track;
  logic [KB-1:0]         head_track;
  clq_pkg::entry_t       new_entry;
  clq_pkg::op_t          op_u;
  clq_pkg::op_t          op_l;
  clq_pkg::entry_t       head_u;
  clq_pkg::entry_t       head_l;
  logic [clq_pkg::CNT_W-1:0] cnt_u;
  logic [clq_pkg::CNT_W-1:0] cnt_l;
  logic                  full_u, full_l, empty_u, empty_l;
  logic                  to_upper;

  logic                  r_valid;
  logic [TB-1:0]         r_tag;
  logic [KB-1:0]         r_track;
  logic [1:0]            r_status;
  logic                  r_qempty;

  logic                  r_valid_next;
  logic [TB-1:0]         r_tag_next;
  logic [KB-1:0]         r_track_next;
  logic [1:0]            r_status_next;
  logic                  r_qempty_next;

  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign is_get     = (s_tuser[0] == clq_pkg::FUNC_GET);
  assign req_tag    = s_tdata[TB-1:0];
  assign req_track  = s_tdata[TB+KB-1:TB];
  assign head_track = s_tdata[TB+2*KB-1:TB+KB];
  assign new_entry  = '{tag: req_tag, track: req_track};
  assign to_upper   = (head_track <= req_track);

  always_comb begin
    op_u.ins = accept && !is_get && to_upper && !full_u;
    op_l.ins = accept && !is_get && !to_upper && !full_l;
    op_u.pop = accept && is_get && !empty_u;
    op_l.pop = accept && is_get && empty_u && !empty_l;
  end

  clq_store u_upper (
    .clk       (clk),
    .rst       (rst),
    .op        (op_u),
    .new_entry (new_entry),
    .head      (head_u),
    .count     (cnt_u),
    .full      (full_u),
    .empty     (empty_u)
  );

  clq_store u_lower (
    .clk       (clk),
    .rst       (rst),
    .op        (op_l),
    .new_entry (new_entry),
    .head      (head_l),
    .count     (cnt_l),
    .full      (full_l),
    .empty     (empty_l)
  );

  always_comb begin
    r_valid_next  = 1'b0;
    r_tag_next    = '0;
    r_track_next  = '0;
    r_status_next = clq_pkg::STATUS_OK;
    r_qempty_next = empty_u && empty_l;
    if (is_get) begin
      if (op_u.pop) begin
        r_valid_next  = 1'b1;
        r_tag_next    = head_u.tag;
        r_track_next  = head_u.track;
        r_qempty_next = (cnt_u == clq_pkg::CNT_W'(1)) && empty_l;
      end else if (op_l.pop) begin
        r_valid_next  = 1'b1;
        r_tag_next    = head_l.tag;
        r_track_next  = head_l.track;
        r_qempty_next = (cnt_l == clq_pkg::CNT_W'(1));
      end else begin
        r_status_next = clq_pkg::STATUS_EMPTY;
      end
    end else if (op_u.ins || op_l.ins) begin
      r_qempty_next = 1'b0;
    end else begin
      r_status_next = clq_pkg::STATUS_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_valid  <= r_valid_next;
      r_tag    <= r_tag_next;
      r_track  <= r_track_next;
      r_status <= r_status_next;
      r_qempty <= r_qempty_next;
    end
  end

  assign m_tdata = {7'd0, r_qempty, r_track, r_tag};
  assign m_tuser = {r_status, r_valid};

  // A result word is always presented the cycle after an input word is taken.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("no result after accepted word");

  // A popped request never carries an error status.
  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && r_valid) |-> (r_status == clq_pkg::STATUS_OK))
    else $error("popped request with error status");

  // Fill counts never pass the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt_u <= clq_pkg::CNT_W'(clq_pkg::DEPTH)) &&
    (cnt_l <= clq_pkg::CNT_W'(clq_pkg::DEPTH)))
    else $error("store count overflow");

  // The lower store is only popped while the upper store is empty.
  a_lower_order: assert property (@(posedge clk) disable iff (rst)
    op_l.pop |-> (empty_u && !op_u.pop))
    else $error("lower store popped ahead of upper");

endmodule
`default_nettype wire
